// ===== rtl/core/srxp_pkg.sv =====
// Shared types and codes for the selected-row XOR parity block.
// Used by the front, the back end and the top level.
package srxp_pkg;

  // Default sizing
  localparam int MaxRowsDef    = 256;
  localparam int MaxRowWordsDef = 16;
  localparam int WordBitsDef   = 64;

  // Port field widths
  localparam int InDataW  = 88;
  localparam int OutDataW = 72;
  localparam int CfgDataW = 9;

  // Reset values of the configuration registers
  localparam logic [4:0] RowWordsRst  = 5'd4;
  localparam logic [8:0] RowsInUseRst = 9'd256;

  // Configuration register indexes
  localparam logic CFG_ROW_WORDS   = 1'b0;
  localparam logic CFG_ROWS_IN_USE = 1'b1;

  // Item kinds
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_FOLD  = 1'b1;

  // Set start modes
  localparam logic [1:0] MODE_FRESH = 2'd0;
  localparam logic [1:0] MODE_COPY  = 2'd1;
  localparam logic [1:0] MODE_KEEP  = 2'd2;

  // Control flags of one queued item
  typedef struct packed {
    logic is_fold;  // fold a row, else store a word
    logic clear;    // open the set from a zero parity
    logic skip;     // row out of range or write rejected
    logic last;     // emit the parity after this item
  } srxp_ctl_t;

  localparam int CtlW = $bits(srxp_ctl_t);

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_WAIT,
    BK_EMIT
  } srxp_bk_state_t;

endpackage

// ===== rtl/core/selected_row_xor_parity.sv =====
// Selected-row XOR parity: row database with a running XOR parity over chosen rows.
// Sequencing: the back end writes a word store into row memory as it pops it; a row fold
// reads row memory once per word (BK_READ), then settles the fold in BK_WAIT;
// a set's last fold then emits row_words result words at one per cycle while out_tready allows.
// Reset clears the parity, sets row_words to 4 and rows_in_use to 256; row memory is not
// cleared. Built from srxp_front, srxp_fifo and srxp_back, using srxp_pkg.
module selected_row_xor_parity #(
  parameter int MAX_ROWS      = srxp_pkg::MaxRowsDef,
  parameter int MAX_ROW_WORDS = srxp_pkg::MaxRowWordsDef,
  parameter int WORD_BITS     = srxp_pkg::WordBitsDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [srxp_pkg::CfgDataW-1:0] cfg_data,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // row_index[15:0], word_index[19:16], data[83:20], start_set[84], set_mode[86:85]
  input  logic [srxp_pkg::InDataW-1:0]  in_tdata,
  input  logic                          in_tuser,  // func
  input  logic                          in_tlast,  // last_item
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_word_index[3:0], parity_word[67:4]
  output logic [srxp_pkg::OutDataW-1:0] out_tdata,
  output logic                          out_tlast  // last_word
);

  localparam int RW_W   = $clog2(MAX_ROW_WORDS + 1);
  localparam int ADDR_W = $clog2(MAX_ROWS * MAX_ROW_WORDS);
  localparam int ENT_W  = srxp_pkg::CtlW + RW_W + ADDR_W + WORD_BITS;

  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic [ENT_W-1:0] q_wdata;
  logic [ENT_W-1:0] q_rdata;

  srxp_front #(
    .MAX_ROWS      (MAX_ROWS),
    .MAX_ROW_WORDS (MAX_ROW_WORDS),
    .WORD_BITS     (WORD_BITS),
    .RW_W          (RW_W),
    .ADDR_W        (ADDR_W),
    .ENT_W         (ENT_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  srxp_fifo #(
    .W (ENT_W)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  srxp_back #(
    .MAX_ROWS      (MAX_ROWS),
    .MAX_ROW_WORDS (MAX_ROW_WORDS),
    .WORD_BITS     (WORD_BITS),
    .RW_W          (RW_W),
    .ADDR_W        (ADDR_W),
    .ENT_W         (ENT_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/core/srxp_front.sv =====
// Front end: configuration registers, input acceptance and item classification.
// Depends on srxp_pkg; feeds one packed entry per accepted item to the queue.
module srxp_front #(
  parameter int MAX_ROWS      = srxp_pkg::MaxRowsDef,
  parameter int MAX_ROW_WORDS = srxp_pkg::MaxRowWordsDef,
  parameter int WORD_BITS     = srxp_pkg::WordBitsDef,
  parameter int RW_W          = $clog2(MAX_ROW_WORDS + 1),
  parameter int ADDR_W        = $clog2(MAX_ROWS * MAX_ROW_WORDS),
  parameter int ENT_W         = srxp_pkg::CtlW + RW_W + ADDR_W + WORD_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // row_index[15:0], word_index[19:16], data[83:20], start_set[84], set_mode[86:85]
  input  logic [srxp_pkg::InDataW-1:0] in_tdata,
  input  logic                        in_tuser,  // func
  input  logic                        in_tlast,  // last_item
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [srxp_pkg::CfgDataW-1:0] cfg_data,
  // queue side
  input  logic                        q_full,
  output logic                        q_push,
  output logic [ENT_W-1:0]            q_wdata
);

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [4:0]        row_words_r;
  logic [8:0]        rows_in_use_r;
  logic [15:0]       row;
  logic [3:0]        word;
  logic              start;
  logic [1:0]        mode;
  logic [RW_W-1:0]   rw_eff;
  logic [ROW_W-1:0]  row_lo;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] addr;
  logic              fold_ok;
  logic              wr_ok;
  srxp_pkg::srxp_ctl_t ctl;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Update configuration registers on a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_words_r   <= srxp_pkg::RowWordsRst;
      rows_in_use_r <= srxp_pkg::RowsInUseRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        srxp_pkg::CFG_ROW_WORDS:   row_words_r   <= cfg_data[4:0];
        srxp_pkg::CFG_ROWS_IN_USE: rows_in_use_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack input fields
  assign row   = in_tdata[15:0];
  assign word  = in_tdata[19:16];
  assign start = in_tdata[84];
  assign mode  = in_tdata[86:85];

  // Clamp row length into 1..MAX_ROW_WORDS
  always_comb begin
    if (row_words_r == 5'd0) begin
      rw_eff = RW_W'(1);
    end else if (32'(row_words_r) > MAX_ROW_WORDS) begin
      rw_eff = RW_W'(MAX_ROW_WORDS);
    end else begin
      rw_eff = RW_W'(row_words_r);
    end
  end

  // Row base address and word address
  assign row_lo = ROW_W'(row);
  assign base   = ADDR_W'(row_lo) * ADDR_W'(rw_eff);
  assign addr   = base + ADDR_W'(word);

  // Range checks
  assign fold_ok = (32'(row) < 32'(rows_in_use_r)) && (32'(row) < MAX_ROWS);
  assign wr_ok   = (32'(row) < MAX_ROWS) && (32'(word) < 32'(rw_eff));

  // Classify the item
  always_comb begin
    ctl.is_fold = (in_tuser == srxp_pkg::FUNC_FOLD);
    ctl.clear   = ctl.is_fold && start && (mode == srxp_pkg::MODE_FRESH);
    ctl.skip    = ctl.is_fold ? !fold_ok : !wr_ok;
    ctl.last    = ctl.is_fold && in_tlast;
  end

  assign q_wdata = {ctl, rw_eff, (ctl.is_fold ? base : addr), in_tdata[20 +: WORD_BITS]};

endmodule

// ===== rtl/core/srxp_fifo.sv =====
// Two-entry queue between the front end and the back end.
// Depends on nothing; width is set by the instantiating level.
module srxp_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] ent_r [2];
  logic         wp_r;
  logic         rp_r;
  logic [1:0]   cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = ent_r[rp_r];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= wdata;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/srxp_back.sv =====
// Back end: row memory, parity registers and the fold/emit sequencer.
// Depends on srxp_pkg; pops entries from srxp_fifo and drives the result stream.
module srxp_back #(
  parameter int MAX_ROWS      = srxp_pkg::MaxRowsDef,
  parameter int MAX_ROW_WORDS = srxp_pkg::MaxRowWordsDef,
  parameter int WORD_BITS     = srxp_pkg::WordBitsDef,
  parameter int RW_W          = $clog2(MAX_ROW_WORDS + 1),
  parameter int ADDR_W        = $clog2(MAX_ROWS * MAX_ROW_WORDS),
  parameter int ENT_W         = srxp_pkg::CtlW + RW_W + ADDR_W + WORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // queue side
  input  logic                         q_empty,
  input  logic [ENT_W-1:0]             q_rdata,
  output logic                         q_pop,
  // result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [srxp_pkg::OutDataW-1:0] out_tdata,
  output logic                         out_tlast
);

  localparam int DEPTH  = MAX_ROWS * MAX_ROW_WORDS;
  localparam int WIDX_W = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;

  srxp_pkg::srxp_ctl_t ctl;
  logic [RW_W-1:0]      e_rw;
  logic [ADDR_W-1:0]    e_addr;
  logic [WORD_BITS-1:0] e_data;

  srxp_pkg::srxp_bk_state_t st_r, st_nxt;
  logic [WIDX_W-1:0]    w_r;
  logic [RW_W-1:0]      rw_r;
  logic [ADDR_W-1:0]    base_r;
  logic                 last_r;
  logic                 xv_r;
  logic [WIDX_W-1:0]    xidx_r;
  logic [WORD_BITS-1:0] rd_q;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] par_r [MAX_ROW_WORDS];
  logic [MAX_ROW_WORDS-1:0] pvld_r;

  logic                 out_tvalid_r;
  logic [3:0]           out_idx_r;
  logic [WORD_BITS-1:0] out_par_r;
  logic                 out_last_r;

  logic                 w_is_last;
  logic                 mem_we;
  logic                 issue;
  logic                 out_load;
  logic                 do_clear;
  logic [WIDX_W-1:0]    pidx;
  logic [WORD_BITS-1:0] pval;

  assign {ctl, e_rw, e_addr, e_data} = q_rdata;

  assign w_is_last = (RW_W'(w_r) + RW_W'(1) == rw_r);

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      srxp_pkg::BK_IDLE: begin
        if (!q_empty && ctl.is_fold) begin
          if (!ctl.skip) begin
            st_nxt = srxp_pkg::BK_READ;
          end else if (ctl.last) begin
            st_nxt = srxp_pkg::BK_EMIT;
          end
        end
      end
      srxp_pkg::BK_READ: begin
        if (w_is_last) begin
          st_nxt = srxp_pkg::BK_WAIT;
        end
      end
      srxp_pkg::BK_WAIT: begin
        st_nxt = last_r ? srxp_pkg::BK_EMIT : srxp_pkg::BK_IDLE;
      end
      srxp_pkg::BK_EMIT: begin
        if (out_load && w_is_last) begin
          st_nxt = srxp_pkg::BK_IDLE;
        end
      end
      default: st_nxt = srxp_pkg::BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop    = 1'b0;
    mem_we   = 1'b0;
    do_clear = 1'b0;
    issue    = 1'b0;
    out_load = 1'b0;
    unique case (st_r)
      srxp_pkg::BK_IDLE: begin
        q_pop    = !q_empty;
        mem_we   = !q_empty && !ctl.is_fold && !ctl.skip;
        do_clear = !q_empty && ctl.is_fold && ctl.clear;
      end
      srxp_pkg::BK_READ: issue = 1'b1;
      srxp_pkg::BK_WAIT: ;
      srxp_pkg::BK_EMIT: out_load = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= srxp_pkg::BK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Hold the current item's shape and step the word counter
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rw_r   <= e_rw;
      base_r <= e_addr;
      last_r <= ctl.last;
      w_r    <= '0;
    end else if (issue || out_load) begin
      w_r <= w_is_last ? '0 : w_r + WIDX_W'(1);
    end
  end

  // Row memory: one write port for stores, one registered read port for folds
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[e_addr] <= e_data;
    end
    rd_q <= mem[base_r + ADDR_W'(w_r)];
  end

  // Track which word the returning read data belongs to
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xv_r <= 1'b0;
    end else begin
      xv_r <= issue;
    end
    xidx_r <= w_r;
  end

  // Parity word read; an entry that is not valid reads as zero
  assign pidx = (st_r == srxp_pkg::BK_EMIT) ? w_r : xidx_r;
  assign pval = pvld_r[pidx] ? par_r[pidx] : '0;

  // Fold read data into the parity
  always_ff @(posedge clk) begin
    if (xv_r) begin
      par_r[xidx_r] <= pval ^ rd_q;
    end
  end

  // Valid bits: set on fold, drop all when a fresh set opens
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= '0;
    end else begin
      if (xv_r) begin
        pvld_r[xidx_r] <= 1'b1;
      end
      if (do_clear) begin
        pvld_r <= '0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r  <= 4'(w_r);
      out_par_r  <= pval;
      out_last_r <= w_is_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(srxp_pkg::OutDataW - 68)'(0), 64'(out_par_r), out_idx_r};

endmodule
